// ===== design/assert_macros.svh =====
// Assertion helpers shared by the console writer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
  `ASSERT_CLK(label, clk, rstn, !(expr), msg)

`endif

// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// No dependencies; used by the top level.
package tcw_pkg;

  // Field widths fixed by the item format
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFS_W  = 11;
  localparam int CELL_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Cell format and control codes
  localparam logic [7:0]        ATTR_GRAY   = 8'h07;
  localparam logic [7:0]        GLYPH_SPACE = 8'h20;
  localparam logic [CELL_W-1:0] BLANK_CELL  = {ATTR_GRAY, GLYPH_SPACE};
  localparam logic [CHAR_W-1:0] CODE_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR     = 8'h0D;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,       // clearing pass after reset
    ST_IDLE,       // waiting for an item
    ST_READ_WAIT,  // buffer read in flight
    ST_CLEAR,      // blanking every cell for a clear item
    ST_COPY,       // moving rows up by one
    ST_BLANK,      // blanking the bottom row after a scroll
    ST_DELIVER     // result waiting for the output register
  } tcw_state_t;

endpackage

// ===== design/text_console_writer_unit.sv =====
`timescale 1ns / 1ps
// Text console writer: cursor, control codes, scroll and clear sequencer.
// Depends on tcw_pkg, tcw_ram and assert_macros.svh.
//
// A ROWS x COLUMNS buffer of 16-bit cells sits in one RAM with one write
// and one registered read port; every item yields one result. Puts of
// printable bytes and control codes, and unused operations, are taken one
// per cycle while the output is not stalled. A read waits for the RAM's
// registered read port. A clear writes a blank to every cell and a put that
// scrolls copies every row up and blanks the bottom row, since every cell
// passes through the single write port. After reset the block blanks the
// buffer and takes no item until that pass ends.
`include "assert_macros.svh"

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tcw_pkg::OP_W-1:0]   in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0] in_character,
  input  logic [tcw_pkg::IDX_W-1:0]  in_cell_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tcw_pkg::COL_W-1:0]  out_cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [tcw_pkg::OFS_W-1:0]  out_cursor_offset,
  output logic [tcw_pkg::CELL_W-1:0] out_cell_value,
  output logic                       out_scrolled
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] COPY_LEN = CNT_W'((ROWS - 1) * COLUMNS);
  localparam logic [CNT_W-1:0] CNT_COLS = CNT_W'(COLUMNS);
  localparam logic [CMP_W-1:0] CMP_COLS = CMP_W'(COLUMNS);
  localparam logic [CMP_W-1:0] CMP_CELLS = CMP_W'(CELL_COUNT);
  localparam logic [COL_W:0]   COL_LIM  = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]   ROW_LIM  = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  // Sequencer and cursor state
  tcw_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  // Result held until the output register is free
  logic [COL_W-1:0]  pend_col_r, pend_col_nxt;
  logic [ROW_W-1:0]  pend_row_r, pend_row_nxt;
  logic [OFS_W-1:0]  pend_ofs_r, pend_ofs_nxt;
  logic [CELL_W-1:0] pend_cell_r, pend_cell_nxt;
  logic              pend_scr_r, pend_scr_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [OFS_W-1:0]  out_ofs_r;
  logic [CELL_W-1:0] out_cell_r;
  logic              out_scr_r;
  logic              out_load;

  // Buffer port
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [CELL_W-1:0] ram_rd_data;

  // Handshake
  logic slot_free, in_ready, accept;

  // Put decode
  logic [COL_W:0]    put_col;
  logic [ROW_W:0]    put_row;
  logic              put_print, put_scroll;
  logic [COL_W-1:0]  put_col_f;
  logic [ROW_W-1:0]  put_row_f;
  logic [CMP_W-1:0]  cur_pos, put_pos, idx_ext;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_buf (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Accept in idle, or while handing the previous result to the output
  assign slot_free = !out_valid_r || !out_stall;
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_DELIVER) && slot_free);
  assign in_stall  = !in_ready;
  assign accept    = in_valid && in_ready;
  assign out_load  = (state_r == ST_DELIVER) && slot_free;

  // Cursor positions as linear offsets
  assign cur_pos = CMP_W'(row_r) * CMP_COLS + CMP_W'(col_r);
  assign put_pos = CMP_W'(put_row_f) * CMP_COLS + CMP_W'(put_col_f);
  assign idx_ext = CMP_W'(in_cell_index);

  // Decode a put: control codes, column wrap, scroll
  always_comb begin
    put_print = 1'b0;
    put_col   = (COL_W + 1)'(col_r);
    put_row   = (ROW_W + 1)'(row_r);
    if ((in_character == CODE_BS) && (col_r != '0)) begin
      put_col = (COL_W + 1)'(col_r) - (COL_W + 1)'(1);
    end else if (in_character == CODE_CR) begin
      put_col = '0;
    end else if (in_character == CODE_LF) begin
      put_col = '0;
      put_row = (ROW_W + 1)'(row_r) + (ROW_W + 1)'(1);
    end else if (in_character == CODE_TAB) begin
      put_col = (COL_W + 1)'(col_r);
    end else begin
      put_print = 1'b1;
      put_col   = (COL_W + 1)'(col_r) + (COL_W + 1)'(1);
    end
    if (put_col >= COL_LIM) begin
      put_col = '0;
      put_row = put_row + (ROW_W + 1)'(1);
    end
    put_scroll = (put_row >= ROW_LIM);
    put_col_f  = put_scroll ? '0 : put_col[COL_W-1:0];
    put_row_f  = put_scroll ? ROW_LAST : put_row[ROW_W-1:0];
  end

  // Next state, buffer accesses and pending result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    rd_ok_nxt     = rd_ok_r;
    pend_col_nxt  = pend_col_r;
    pend_row_nxt  = pend_row_r;
    pend_ofs_nxt  = pend_ofs_r;
    pend_cell_nxt = pend_cell_r;
    pend_scr_nxt  = pend_scr_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = cnt_r[ADDR_W-1:0];
    ram_wr_data   = BLANK_CELL;
    ram_rd_addr   = '0;

    case (state_r)
      ST_INIT, ST_CLEAR: begin
        // Sweep blanks over every cell
        ram_wr_en = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DELIVER;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_READ_WAIT: begin
        pend_cell_nxt = rd_ok_r ? ram_rd_data : '0;
        state_nxt     = ST_DELIVER;
      end
      ST_COPY: begin
        // Read one row below, write back the word read last cycle
        if (cnt_r != COPY_LEN) begin
          ram_rd_addr = ADDR_W'(cnt_r + CNT_COLS);
        end
        if (cnt_r != '0) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ADDR_W'(cnt_r - CNT_W'(1));
          ram_wr_data = ram_rd_data;
        end
        if (cnt_r == COPY_LEN) begin
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_BLANK: begin
        ram_wr_en = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DELIVER;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DELIVER: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Start a new item
    if (accept) begin
      pend_col_nxt  = col_r;
      pend_row_nxt  = row_r;
      pend_ofs_nxt  = cur_pos[OFS_W-1:0];
      pend_cell_nxt = '0;
      pend_scr_nxt  = 1'b0;
      state_nxt     = ST_DELIVER;
      case (in_operation)
        OP_PUT: begin
          if (put_print) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_pos[ADDR_W-1:0];
            ram_wr_data = {ATTR_GRAY, in_character};
          end
          col_nxt      = put_col_f;
          row_nxt      = put_row_f;
          pend_col_nxt = put_col_f;
          pend_row_nxt = put_row_f;
          pend_ofs_nxt = put_pos[OFS_W-1:0];
          pend_scr_nxt = put_scroll;
          if (put_scroll) begin
            cnt_nxt   = '0;
            state_nxt = ST_COPY;
          end
        end
        OP_CLEAR: begin
          col_nxt      = '0;
          row_nxt      = '0;
          pend_col_nxt = '0;
          pend_row_nxt = '0;
          pend_ofs_nxt = '0;
          cnt_nxt      = '0;
          state_nxt    = ST_CLEAR;
        end
        OP_READ: begin
          ram_rd_addr = idx_ext[ADDR_W-1:0];
          rd_ok_nxt   = (idx_ext < CMP_CELLS);
          state_nxt   = ST_READ_WAIT;
        end
        default: begin
          state_nxt = ST_DELIVER;
        end
      endcase
    end
  end

  // Output valid: load from pending, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_ok_r     <= rd_ok_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_ofs_r  <= pend_ofs_nxt;
    pend_cell_r <= pend_cell_nxt;
    pend_scr_r  <= pend_scr_nxt;
    if (out_load) begin
      out_col_r  <= pend_col_r;
      out_row_r  <= pend_row_r;
      out_ofs_r  <= pend_ofs_r;
      out_cell_r <= pend_cell_r;
      out_scr_r  <= pend_scr_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_offset = out_ofs_r;
  assign out_cell_value    = out_cell_r;
  assign out_scrolled      = out_scr_r;

  // Cursor stays inside the buffer
  `ASSERT_NEVER(a_cursor_range, clk, rst_n,
    (int'(col_r) >= COLUMNS) || (int'(row_r) >= ROWS), "cursor left the buffer")
  // A waiting result is held until the output register frees up
  `ASSERT_CLK(a_deliver_hold, clk, rst_n,
    ((state_r == ST_DELIVER) && out_valid_r && out_stall) |=> (state_r == ST_DELIVER),
    "pending result dropped")
  // No buffer write while a read is in flight
  `ASSERT_CLK(a_read_no_write, clk, rst_n,
    (state_r == ST_READ_WAIT) |-> !ram_wr_en, "buffer written during read")
  // Row copy always ends with blanking the bottom row
  `ASSERT_CLK(a_copy_then_blank, clk, rst_n,
    ((state_r == ST_COPY) && (state_nxt != ST_COPY)) |-> (state_nxt == ST_BLANK),
    "scroll skipped bottom row blanking")

endmodule

// ===== design/tcw_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== test/text_console_writer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_unit: a clocked driver and monitor
// against a cycle-free model of the cell buffer and cursor. Depends on tcw_pkg.
module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    int                idle_pct;
    int                stall_pct;
    bit                drain;
  } console_item_t;

  typedef struct {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [OFS_W-1:0]  ofs;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } console_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_operation = '0;
  logic [CHAR_W-1:0] in_character = '0;
  logic [IDX_W-1:0] in_cell_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COL_W-1:0] out_cursor_column;
  logic [ROW_W-1:0] out_cursor_row;
  logic [OFS_W-1:0] out_cursor_offset;
  logic [CELL_W-1:0] out_cell_value;
  logic out_scrolled;

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_character(in_character),
    .in_cell_index(in_cell_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cursor_column(out_cursor_column),
    .out_cursor_row(out_cursor_row),
    .out_cursor_offset(out_cursor_offset),
    .out_cell_value(out_cell_value),
    .out_scrolled(out_scrolled)
  );

  always #5 clk = ~clk;

  // Model of the console: cell buffer and cursor
  logic [CELL_W-1:0] screen_model [0:CELLS-1];
  int unsigned col_model;
  int unsigned row_model;

  console_item_t   console_items_q [$];
  console_result_t predicted_console_q [$];
  console_item_t   item_on_bus;

  int acc_count = 0;
  int got_count = 0;
  int stall_pct = 0;
  int errors = 0;
  int n_put = 0, n_read = 0, n_clear = 0, n_unused = 0, n_scroll = 0;

  // Generator settings applied to items as they are queued
  int  gen_idle = 0;
  int  gen_stall = 0;
  bit  gen_drain = 1'b0;
  int  gen_count = 0;

  function automatic console_result_t apply_console_item(console_item_t it);
    console_result_t r;
    int unsigned pos;
    r = '{default: '0};
    if (it.op == OP_PUT) begin
      if (it.ch == CODE_BS && col_model > 0) begin
        col_model--;
      end else if (it.ch == CODE_CR) begin
        col_model = 0;
      end else if (it.ch == CODE_LF) begin
        col_model = 0;
        row_model++;
      end else if (it.ch != CODE_TAB) begin
        // printable byte, or backspace at column zero
        pos = row_model * COLUMNS + col_model;
        if (pos < CELLS) screen_model[pos] = {ATTR_GRAY, it.ch};
        col_model++;
      end
      if (col_model >= COLUMNS) begin
        col_model = 0;
        row_model++;
      end
      // scroll up one row past the bottom
      if (row_model >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        col_model = 0;
        row_model = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end else if (it.op == OP_CLEAR) begin
      for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
      col_model = 0;
      row_model = 0;
    end else if (it.op == OP_READ) begin
      if (it.idx < CELLS) r.cell_val = screen_model[it.idx];
    end
    r.col = col_model[COL_W-1:0];
    r.row = row_model[ROW_W-1:0];
    r.ofs = OFS_W'(row_model * COLUMNS + col_model);
    return r;
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
    console_item_t it;
    it.op = op;
    it.ch = ch;
    it.idx = idx;
    it.idle_pct = gen_idle;
    it.stall_pct = gen_stall;
    it.drain = gen_drain;
    gen_drain = 1'b0;
    console_items_q.push_back(it);
    gen_count++;
  endtask

  // Put items carry a random index and read items a random byte, so unused bits toggle too
  task automatic queue_put(input logic [CHAR_W-1:0] ch);
    queue_item(OP_PUT, ch, IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic queue_read(input int idx);
    queue_item(OP_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(idx));
  endtask

  function automatic logic [CHAR_W-1:0] random_glyph();
    if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'($urandom_range(32, 126));
  endfunction

  task automatic check_field(input string name, input int unsigned expv, input int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, expv, actv);
      errors++;
    end
  endtask

  // Driver: present queued items, predict each accepted one
  always @(posedge clk) begin
    console_item_t nxt;
    console_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        res = apply_console_item(item_on_bus);
        predicted_console_q.push_back(res);
        acc_count <= acc_count + 1;
        case (item_on_bus.op)
          OP_PUT:   n_put++;
          OP_CLEAR: n_clear++;
          OP_READ:  n_read++;
          default:  n_unused++;
        endcase
        if (res.scrolled) n_scroll++;
      end
      if (!in_valid || !in_stall) begin
        if (console_items_q.size() > 0 &&
            (!console_items_q[0].drain || (!in_valid && acc_count == got_count)) &&
            $urandom_range(0, 99) >= console_items_q[0].idle_pct) begin
          nxt = console_items_q.pop_front();
          item_on_bus = nxt;
          in_valid <= 1'b1;
          in_operation <= nxt.op;
          in_character <= nxt.ch;
          in_cell_index <= nxt.idx;
          stall_pct <= nxt.stall_pct;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall, compare each result with the oldest prediction
  always @(posedge clk) begin
    console_result_t expr;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (out_valid && !out_stall) begin
        got_count <= got_count + 1;
        if (got_count >= acc_count || predicted_console_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got column %0d row %0d cell %0h",
                   $time, out_cursor_column, out_cursor_row, out_cell_value);
          errors++;
        end else begin
          expr = predicted_console_q.pop_front();
          check_field("cursor_column", expr.col, out_cursor_column);
          check_field("cursor_row", expr.row, out_cursor_row);
          check_field("cursor_offset", expr.ofs, out_cursor_offset);
          check_field("cell_value", expr.cell_val, out_cell_value);
          check_field("scrolled", expr.scrolled, out_scrolled);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int phase;
    int kind;
    int n;
    int r;
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    col_model = 0;
    row_model = 0;

    // Directed: extreme bytes, every control code, reads in and out of range
    queue_put(8'h48);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(CODE_BS);
    queue_put(CODE_TAB);
    queue_read(0);
    queue_read(2);
    queue_put(CODE_CR);
    queue_put(CODE_BS);            // backspace at column zero prints as a glyph
    queue_read(0);
    queue_put(CODE_LF);
    queue_read(CELLS - 1);
    queue_read(CELLS);
    queue_read(2047);
    queue_item(OP_UNUSED, 8'hFF, 11'h7FF);
    queue_item(OP_UNUSED, 8'h00, 11'h000);
    queue_item(OP_CLEAR, 8'hFF, 11'h7FF);
    queue_read(2);
    queue_read(COLUMNS);
    queue_put(8'h7F);
    queue_put(8'h80);
    queue_read(0);
    queue_read(1);

    // Random: mostly text lines with reads, some noise; phases of idling
    while (gen_count < RANDOM_ITEMS + 23) begin
      n = (gen_count - 23) * 5 / RANDOM_ITEMS;
      if (n > 4) n = 4;
      if (n != phase || gen_count == 23) begin
        phase = n;
        gen_drain = 1'b1;
      end
      case (phase)
        1:       begin gen_idle = 85; gen_stall = 0;  end
        2:       begin gen_idle = 0;  gen_stall = 85; end
        3:       begin gen_idle = 34; gen_stall = 34; end
        default: begin gen_idle = 0;  gen_stall = 0;  end
      endcase
      // leave some stretches without idling in every phase
      if ($urandom_range(0, 4) == 0) begin
        gen_idle = 0;
        gen_stall = 0;
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        n = $urandom_range(1, 20);
        repeat (n) queue_put(random_glyph());
        r = $urandom_range(0, 99);
        if (r < 60) queue_put(CODE_LF);
        else if (r < 75) queue_put(CODE_CR);
        else if (r < 80) queue_put(CODE_TAB);
      end else if (kind < 70) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 45) queue_read($urandom_range(0, CELLS - 1));
          else if (r < 90) queue_read($urandom_range((ROWS - 5) * COLUMNS, CELLS - 1));
          else queue_read($urandom_range(CELLS, 2047));
        end
      end else if (kind < 78) begin
        n = $urandom_range(1, 3);
        repeat (n) queue_put(CODE_BS);
      end else if (kind < 83) begin
        n = $urandom_range(COLUMNS - 5, COLUMNS + 5);
        repeat (n) queue_put(random_glyph());
      end else if (kind < 88) begin
        n = $urandom_range(3, 10);
        repeat (n) queue_put(CODE_LF);
      end else if (kind < 95) begin
        r = $urandom_range(0, 2);
        if (r == 0)
          queue_item(OP_UNUSED, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
        else if (r == 1) queue_put(CODE_TAB);
        else queue_put(CODE_CR);
      end else if (kind < 97) begin
        queue_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
      end else begin
        queue_read($urandom_range(0, 5 * COLUMNS - 1));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every result to arrive
    while (console_items_q.size() > 0 || in_valid || acc_count != got_count) @(posedge clk);
    repeat (50) @(posedge clk);
    if (predicted_console_q.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, predicted_console_q.size());
      errors++;
    end

    $display("Covered %0d items: %0d puts with %0d scrolls, %0d reads, %0d clears, %0d unused ops.",
             acc_count, n_put, n_scroll, n_read, n_clear, n_unused);
    $display("Idling phases: none, sender, receiver, both; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every item a full scroll under stall)
  initial begin
    #300_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
